// ----- sv/iso_surface_cell_classifier_assert.svh -----
// Assertion macros for the iso-surface cell classifier.
// All checks are sampled on clk_i and disabled while rst_ni is low.
`ifndef ISO_SURFACE_CELL_CLASSIFIER_ASSERT_SVH
`define ISO_SURFACE_CELL_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ISC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isc assertion failed");
`define ISC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isc assertion failed");
`else
`define ISC_ASSERT_IMP(lbl, ante, cons)
`define ISC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/isc_pkg.sv -----
// ----------------------------------------------------------------------------
// isc_pkg
// Types and constants shared by the iso-surface cell classifier modules.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int unsigned RowDepth  = 256;
  localparam int unsigned RowAw     = $clog2(RowDepth);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QAw       = $clog2(QDepth);
  localparam int unsigned QCntW     = QAw + 1;
  localparam int unsigned CfgAw     = 3;
  localparam int unsigned CfgDw     = 9;
  localparam int unsigned InDw      = 16;
  localparam int unsigned OutDw     = 48;
  localparam logic [8:0]  MinSize   = 9'd2;
  localparam logic [8:0]  MaxWidth  = 9'(RowDepth);
  localparam logic [8:0]  MaxHeight = 9'd256;
  localparam logic [15:0] CountMax  = 16'hFFFF;
  localparam logic [7:0]  CaseNone  = 8'h00;
  localparam logic [7:0]  CaseAll   = 8'hFF;

  typedef enum logic [CfgAw-1:0] {
    RegFrameWidth  = 3'd0,
    RegFrameHeight = 3'd1,
    RegSliceIndex  = 3'd2,
    RegWinStartX   = 3'd3,
    RegWinStartY   = 3'd4,
    RegWinEndX     = 3'd5,
    RegWinEndY     = 3'd6
  } isc_reg_e;

  typedef enum logic {
    KindPoint   = 1'b0,
    KindSummary = 1'b1
  } isc_kind_e;

  // one classified input request, holding up to two results
  typedef struct packed {
    logic        pt;      // a surface point is emitted
    logic        sm;      // end-of-frame summary follows
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [7:0]  cz;
    logic [7:0]  idx;
    logic [15:0] cnt;
  } isc_entry_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             empty;
    logic             full;
  } isc_qstat_t;

endpackage

// ----- sv/isc_front.sv -----
// ----------------------------------------------------------------------------
// isc_front
// Accepts voxel pairs, keeps the line store and neighbors, classifies cells.
// ----------------------------------------------------------------------------
module isc_front import isc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgAw-1:0] cfg_addr_i,
  input  logic [CfgDw-1:0] cfg_data_i,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [InDw-1:0]  s_tdata_i,
  input  isc_qstat_t       q_stat_i,
  output logic             push_o,
  output isc_entry_t       entry_o
);

  logic [8:0] fw_q, fh_q, wsx_q, wsy_q, wex_q, wey_q;
  logic [7:0] sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= MaxWidth;
      fh_q  <= MaxHeight;
      sz_q  <= '0;
      wsx_q <= '0;
      wsy_q <= '0;
      wex_q <= 9'd256;
      wey_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (isc_reg_e'(cfg_addr_i))
        RegFrameWidth:  fw_q  <= cfg_data_i;
        RegFrameHeight: fh_q  <= cfg_data_i;
        RegSliceIndex:  sz_q  <= cfg_data_i[7:0];
        RegWinStartX:   wsx_q <= cfg_data_i;
        RegWinStartY:   wsy_q <= cfg_data_i;
        RegWinEndX:     wex_q <= cfg_data_i;
        RegWinEndY:     wey_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- accept stage: geometry, line store access
  logic       acc;
  logic [8:0] w, h;
  logic [7:0] x, y;
  logic [1:0] cur;
  logic       last_col, last_row;
  logic [7:0] col_q, col_d, row_q, row_d;
  logic [1:0] left_q;
  logic       s1_valid_q;
  logic [QCntW:0] occ;

  assign occ        = {1'b0, q_stat_i.count} + {{QCntW{1'b0}}, s1_valid_q};
  assign s_tready_o = occ < (QCntW+1)'(QDepth);
  assign acc        = s_tvalid_i & s_tready_o;

  always_comb begin
    w = (fw_q < MinSize) ? MinSize : ((fw_q > MaxWidth) ? MaxWidth : fw_q);
    h = (fh_q < MinSize) ? MinSize : ((fh_q > MaxHeight) ? MaxHeight : fh_q);
    x = ({1'b0, col_q} < w) ? col_q : 8'(w - 9'd1);
    y = ({1'b0, row_q} < h) ? row_q : 8'(h - 9'd1);
    cur = {s_tdata_i[15:8] == 8'd1, s_tdata_i[7:0] == 8'd1};
    last_col = ({1'b0, x} == w - 9'd1);
    last_row = ({1'b0, y} == h - 9'd1);
    col_d = last_col ? 8'd0 : x + 8'd1;
    row_d = last_col ? (last_row ? 8'd0 : y + 8'd1) : y;
  end

  logic [1:0] row_mem [RowDepth];
  logic [1:0] above_q;

  // read-before-write: the entry holds the pair from one row up
  always_ff @(posedge clk_i) begin
    if (acc) begin
      above_q          <= row_mem[x[RowAw-1:0]];
      row_mem[x[RowAw-1:0]] <= cur;
    end
  end

  logic [1:0] s1_cur_q, s1_left_q;
  logic [7:0] s1_cx_q, s1_cy_q;
  logic       s1_cell_q, s1_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc;
      if (acc) begin
        col_q  <= col_d;
        row_q  <= row_d;
        left_q <= cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_cur_q  <= cur;
      s1_left_q <= left_q;
      s1_cx_q   <= x - 8'd1;
      s1_cy_q   <= y - 8'd1;
      s1_cell_q <= (x != 8'd0) && (y != 8'd0);
      s1_sum_q  <= last_col & last_row;
    end
  end

  // ---- classify stage
  logic [1:0]  ul_q;
  logic [15:0] pts_q, pts_new;
  logic [7:0]  idx;
  logic        in_win, emit;

  always_comb begin
    // corners: c00 upper-left, c10 above, c11 current, c01 left
    idx = {s1_left_q[1], s1_cur_q[1], above_q[1], ul_q[1],
           s1_left_q[0], s1_cur_q[0], above_q[0], ul_q[0]};
    in_win = ({1'b0, s1_cx_q} >= wsx_q) && ({1'b0, s1_cx_q} < wex_q) &&
             ({1'b0, s1_cy_q} >= wsy_q) && ({1'b0, s1_cy_q} < wey_q);
    emit = s1_cell_q && (idx != CaseNone) && (idx != CaseAll) && in_win;
    pts_new = (emit && pts_q != CountMax) ? pts_q + 16'd1 : pts_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q  <= '0;
      pts_q <= '0;
    end else if (s1_valid_q) begin
      ul_q  <= above_q;
      pts_q <= s1_sum_q ? 16'd0 : pts_new;
    end
  end

  assign push_o      = s1_valid_q & (emit | s1_sum_q);
  assign entry_o.pt  = emit;
  assign entry_o.sm  = s1_sum_q;
  assign entry_o.cx  = s1_cx_q;
  assign entry_o.cy  = s1_cy_q;
  assign entry_o.cz  = sz_q;
  assign entry_o.idx = idx;
  assign entry_o.cnt = pts_new;

endmodule

// ----- sv/isc_queue.sv -----
// ----------------------------------------------------------------------------
// isc_queue
// Short register queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module isc_queue import isc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  isc_entry_t entry_i,
  input  logic       pop_i,
  output isc_entry_t head_o,
  output isc_qstat_t stat_o
);

  isc_entry_t         slot_q [QDepth];
  logic [QAw-1:0]     wr_q, rd_q;
  logic [QCntW-1:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QAw'(1);
      if (pop_i)  rd_q <= rd_q + QAw'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o       = slot_q[rd_q];
  assign stat_o.count = cnt_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));

endmodule

// ----- sv/isc_back.sv -----
// ----------------------------------------------------------------------------
// isc_back
// Expands each queued request into its point and summary results.
// ----------------------------------------------------------------------------
module isc_back import isc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  isc_entry_t       head_i,
  input  isc_qstat_t       q_stat_i,
  output logic             pop_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OutDw-1:0] m_tdata_o,
  output logic             m_tlast_o,
  output logic [0:0]       m_tuser_o
);

  logic             ov_q, ov_d;
  logic             phase_q, phase_d;   // point already sent, summary pending
  logic [OutDw-1:0] data_q, data_d;
  logic             last_q, last_d;
  isc_kind_e        kind_q, kind_d;
  logic             load;

  always_comb begin
    load    = ~ov_q | m_tready_i;
    ov_d    = ov_q;
    phase_d = phase_q;
    data_d  = data_q;
    last_d  = last_q;
    kind_d  = kind_q;
    pop_o   = 1'b0;
    if (load) begin
      ov_d = ~q_stat_i.empty;
      if (!q_stat_i.empty) begin
        if (head_i.pt && !phase_q) begin
          kind_d = KindPoint;
          data_d = {head_i.cnt, head_i.idx, head_i.cz, head_i.cy, head_i.cx};
          last_d = ~head_i.sm;
          if (head_i.sm) begin
            phase_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          kind_d  = KindSummary;
          data_d  = {head_i.cnt, 32'd0};
          last_d  = 1'b1;
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      ov_q    <= ov_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    kind_q <= kind_d;
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = last_q;
  assign m_tuser_o  = kind_q;

endmodule

// ----- sv/iso_surface_cell_classifier.sv -----
// ----------------------------------------------------------------------------
// iso_surface_cell_classifier
// Dividing-cubes cell classification over two voxel slices in raster order.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata: lower_voxel, upper_voxel
//  m_*      out  tvalid/tready      tdata: x,y,z,case,count; tlast; tuser kind
//  cfg_*    in   we (no wait)       addr: register index, data: 9 bits
//
//  One voxel pair per cycle sustained while s_tready is high; a point passes
//  through the line store read, classify, queue and output register in order.
//  The frame summary adds a second output item; the four-entry queue absorbs it.
//  s_tready drops only when the queue plus classify stage are full.
//  Reset puts counters and neighbors at zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module iso_surface_cell_classifier import isc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgAw-1:0] cfg_addr_i,
  input  logic [CfgDw-1:0] cfg_data_i,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [InDw-1:0]  s_tdata_i,   // [7:0] lower_voxel, [15:8] upper_voxel
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  // [7:0] cell_x, [15:8] cell_y, [23:16] cell_z, [31:24] case_index,
  // [47:32] point_count
  output logic [OutDw-1:0] m_tdata_o,
  output logic             m_tlast_o,   // last_of_run
  output logic [0:0]       m_tuser_o    // [0] item_kind
);

  `include "iso_surface_cell_classifier_assert.svh"

  isc_qstat_t q_stat;
  isc_entry_t q_in, q_head;
  logic       q_push, q_pop;

  isc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  isc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  isc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .q_stat_i   (q_stat),
    .pop_o      (q_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

  `ISC_ASSERT_IMP(a_q_no_overflow, q_push && q_stat.full, q_pop)
  `ISC_ASSERT_IMP(a_q_no_underflow, q_pop, !q_stat.empty)
  `ISC_ASSERT_IMP(a_summary_zero, m_tvalid_o && m_tuser_o[0], m_tdata_o[31:0] == 32'd0)
  `ISC_ASSERT_IMP(a_point_case, m_tvalid_o && !m_tuser_o[0],
                  m_tdata_o[31:24] != CaseNone && m_tdata_o[31:24] != CaseAll)
  `ISC_ASSERT_NXT(a_summary_last, m_tvalid_o && m_tready_i && !m_tlast_o,
                  m_tvalid_o && m_tuser_o[0])

endmodule

// ----- tb/tb_iso_surface_cell_classifier.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iso_surface_cell_classifier
// Streams voxel pairs through the cell classifier and checks every emitted
// point and frame summary against a cycle-free model of the classifier. A
// short table of hand-built 2x2 frames comes first, then whole frames of
// random geometry, window and content, some reconfigured mid-frame, under
// varying back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb_iso_surface_cell_classifier import isc_pkg::*; ();

  localparam int DirRows     = 24;
  localparam int RandItems   = 1750;
  localparam int DrainCycles = 10;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 400000;
  localparam logic [CfgAw-1:0] RegSpare = 3'd7;  // no register behind it

  typedef struct packed {
    isc_kind_e   kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic [7:0]  idx;
    logic [15:0] cnt;
    logic        last;
  } cell_res_t;

  // directed row: chk set means the results are typed in here
  typedef struct packed {
    logic [7:0]  lo;
    logic [7:0]  up;
    logic        chk;
    logic [7:0]  idx;   // point case index at (0,0), CaseNone for no point
    logic        sum;   // frame summary follows
    logic [15:0] cnt;
  } vox_row_t;

  // 2x2 frames, slice 255; request order (0,0) (1,0) (0,1) (1,1)
  localparam vox_row_t DirTbl [DirRows] = '{
    '{8'd0,   8'd0,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd0,   8'd0,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd0,   8'd0,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd0,   8'd0,   1'b1, 8'h00, 1'b1, 16'd0},   // all outside: dropped
    '{8'd1,   8'd1,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd1,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd1,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd1,   1'b1, 8'h00, 1'b1, 16'd0},   // all inside: dropped
    '{8'd1,   8'd0,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd0,   8'd0,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd0,   8'd0,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd0,   8'd0,   1'b1, 8'h01, 1'b1, 16'd1},   // lowest index
    '{8'd255, 8'd2,   1'b0, 8'h00, 1'b0, 16'd0},   // values other than 1
    '{8'd0,   8'd255, 1'b0, 8'h00, 1'b0, 16'd0},
    '{8'd2,   8'd1,   1'b0, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd255, 1'b0, 8'h00, 1'b0, 16'd0},
    '{8'd0,   8'd1,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd1,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd1,   1'b1, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd1,   1'b1, 8'hFE, 1'b1, 16'd1},   // highest index
    '{8'd1,   8'd1,   1'b0, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd1,   1'b0, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd1,   1'b0, 8'h00, 1'b0, 16'd0},
    '{8'd1,   8'd0,   1'b0, 8'h00, 1'b0, 16'd0}
  };

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we_i   = 1'b0;
  logic [CfgAw-1:0] cfg_addr_i = '0;
  logic [CfgDw-1:0] cfg_data_i = '0;
  logic             s_tvalid_i = 1'b0;
  logic             s_tready_o;
  logic [InDw-1:0]  s_tdata_i  = '0;   // [7:0] lower_voxel, [15:8] upper_voxel
  logic             m_tvalid_o;
  logic             m_tready_i = 1'b0;
  // [7:0] cell_x, [15:8] cell_y, [23:16] cell_z, [31:24] case_index,
  // [47:32] point_count
  logic [OutDw-1:0] m_tdata_o;
  logic             m_tlast_o;         // last_of_run
  logic [0:0]       m_tuser_o;         // [0] item_kind

  iso_surface_cell_classifier uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .s_tvalid_i, .s_tready_o, .s_tdata_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tlast_o, .m_tuser_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // classifier model state
  logic [8:0] reg_q [8] = '{9'd256, 9'd256, 9'd0, 9'd0, 9'd0, 9'd256, 9'd256, 9'd0};
  logic [1:0] line_mem [256];
  logic [1:0] left_q   = '0;
  logic [1:0] upleft_q = '0;
  int         col_q    = 0;
  int         row_q    = 0;
  int         pts_q    = 0;

  cell_res_t  cells_due [$];
  int         fail_cnt     = 0;
  int         points_seen  = 0;
  int         summaries_seen = 0;
  int         pairs_sent   = 0;
  int         settings_cnt = 0;
  int         cycle_cnt    = 0;
  int         tx_idle_pct  = 0;
  int         rx_idle_pct  = 0;
  bit         hold_arm     = 1'b0;
  bit         hold_seen    = 1'b0;
  int         hold_left    = 0;

  function automatic int clamp_size(input logic [8:0] v, input logic [8:0] hi);
    if (v < MinSize) return int'(MinSize);
    if (v > hi) return int'(hi);
    return int'(v);
  endfunction

  function automatic cell_res_t mk_res(input isc_kind_e k, input int x, input int y,
                                       input int z, input int idx, input int cnt,
                                       input bit last);
    cell_res_t r;
    r.kind = k;
    r.x    = 8'(x);
    r.y    = 8'(y);
    r.z    = 8'(z);
    r.idx  = 8'(idx);
    r.cnt  = 16'(cnt);
    r.last = last;
    return r;
  endfunction

  // advance the model by one voxel pair; keep=0 only updates state
  function automatic void classify_pair(input logic [7:0] lo, input logic [7:0] up,
                                        input bit keep);
    int         w, h, x, y, cx, cy;
    bit         ends_frame;
    logic [1:0] cur, above;
    logic [7:0] idx;
    w = clamp_size(reg_q[RegFrameWidth], MaxWidth);
    h = clamp_size(reg_q[RegFrameHeight], MaxHeight);
    // counts past a shrunk geometry act as the last column / row
    x = (col_q < w) ? col_q : w - 1;
    y = (row_q < h) ? row_q : h - 1;
    ends_frame = (x == w - 1) && (y == h - 1);
    cur   = {up == 8'd1, lo == 8'd1};
    above = line_mem[x];
    if (x > 0 && y > 0) begin
      idx = {left_q[1], cur[1], above[1], upleft_q[1],
             left_q[0], cur[0], above[0], upleft_q[0]};
      cx = x - 1;
      cy = y - 1;
      if (idx != CaseNone && idx != CaseAll &&
          cx >= int'(reg_q[RegWinStartX]) && cx < int'(reg_q[RegWinEndX]) &&
          cy >= int'(reg_q[RegWinStartY]) && cy < int'(reg_q[RegWinEndY])) begin
        if (pts_q < int'(CountMax)) pts_q++;
        if (keep) cells_due.push_back(mk_res(KindPoint, cx, cy,
                                             reg_q[RegSliceIndex][7:0], idx, pts_q,
                                             !ends_frame));
      end
    end
    upleft_q    = above;
    line_mem[x] = cur;
    left_q      = cur;
    if (x == w - 1) begin
      col_q = 0;
      if (ends_frame) begin
        if (keep) cells_due.push_back(mk_res(KindSummary, 0, 0, 0, 0, pts_q, 1'b1));
        row_q = 0;
        pts_q = 0;
      end else begin
        row_q = y + 1;
      end
    end else begin
      col_q = x + 1;
      row_q = y;
    end
  endfunction

  function automatic bit field_bad(input string name, input int e_v, input int a_v);
    if (e_v != a_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, e_v, a_v);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] rand_voxel(input int dens);
    if ($urandom_range(9, 0) == 0) return 8'($urandom_range(255, 0));
    return ($urandom_range(99, 0) < dens) ? 8'd1 : 8'd0;
  endfunction

  function automatic logic [8:0] rand_coord(input int lim);
    case ($urandom_range(3, 0))
      0: begin
        return 9'($urandom_range(511, 0));
      end
      1: begin
        return $urandom_range(1, 0) ? 9'd0 : 9'd256;
      end
      default: begin
        return 9'($urandom_range(lim + 1, 0));
      end
    endcase
  endfunction

  task automatic send(input logic [7:0] lo, input logic [7:0] up, input bit keep);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {up, lo};
    do @(posedge clk_i); while (!s_tready_o);
    classify_pair(lo, up, keep);
    pairs_sent++;
  endtask

  // wait for every outstanding result plus pipeline latency
  task automatic settle();
    s_tvalid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAw-1:0] addr, input logic [8:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_q[addr] = val;
  endtask

  task automatic set_geometry(input logic [8:0] w, input logic [8:0] h,
                              input logic [8:0] z, input logic [8:0] sx,
                              input logic [8:0] sy, input logic [8:0] ex,
                              input logic [8:0] ey);
    settle();
    write_reg(RegFrameWidth, w);
    write_reg(RegFrameHeight, h);
    write_reg(RegSliceIndex, z);
    write_reg(RegWinStartX, sx);
    write_reg(RegWinStartY, sy);
    write_reg(RegWinEndX, ex);
    write_reg(RegWinEndY, ey);
    write_reg(RegSpare, 9'($urandom_range(511, 0)));
    settings_cnt++;
  endtask

  // one full frame; a broken one is reconfigured partway through
  task automatic run_frame(input bit broken);
    int dens, cut, k, cur_w;
    dens  = $urandom_range(100, 0);
    cur_w = clamp_size(reg_q[RegFrameWidth], MaxWidth);
    cut   = broken ? $urandom_range(cur_w * clamp_size(reg_q[RegFrameHeight],
                                                        MaxHeight) - 1, 1) : -1;
    k = 0;
    do begin
      if (k == cut) begin
        settle();
        // width only shrinks mid-frame so no unwritten line entry is read
        write_reg(RegFrameWidth, 9'($urandom_range(cur_w, 0)));
        write_reg(RegFrameHeight, 9'($urandom_range(511, 0)));
        write_reg(RegSliceIndex, 9'($urandom_range(511, 0)));
        write_reg(RegWinStartX, rand_coord(cur_w));
        settings_cnt++;
      end
      send(rand_voxel(dens), rand_voxel(dens), 1'b1);
      k++;
    end while (col_q != 0 || row_q != 0);
  endtask

  // result side: random stalls, plus one long hold-off per arm toggle
  always @(posedge clk_i) begin
    if (hold_arm != hold_seen) begin
      hold_seen  <= hold_arm;
      hold_left  <= HoldCycles;
      m_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_mon
    cell_res_t want;
    int        bad;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (cells_due.size() == 0) begin
        $error("unexpected result: tdata %h tuser %0d", m_tdata_o, m_tuser_o);
        fail_cnt++;
      end else begin
        want = cells_due.pop_front();
        bad = 0;
        bad += field_bad("item_kind", want.kind, m_tuser_o[0]);
        bad += field_bad("cell_x", want.x, m_tdata_o[7:0]);
        bad += field_bad("cell_y", want.y, m_tdata_o[15:8]);
        bad += field_bad("cell_z", want.z, m_tdata_o[23:16]);
        bad += field_bad("case_index", want.idx, m_tdata_o[31:24]);
        bad += field_bad("point_count", want.cnt, m_tdata_o[47:32]);
        bad += field_bad("last_of_run", want.last, m_tlast_o);
        if (bad != 0) fail_cnt++;
        if (want.kind == KindSummary) summaries_seen++;
        else points_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : main_seq
    int ph, w_raw, h_raw;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_geometry(9'd2, 9'd2, 9'd255, 9'd0, 9'd0, 9'd256, 9'd256);
    for (int i = 0; i < DirRows; i++) begin
      if (DirTbl[i].chk) begin
        if (DirTbl[i].idx != CaseNone)
          cells_due.push_back(mk_res(KindPoint, 0, 0, 255, DirTbl[i].idx,
                                     DirTbl[i].cnt, !DirTbl[i].sum));
        if (DirTbl[i].sum)
          cells_due.push_back(mk_res(KindSummary, 0, 0, 0, 0, DirTbl[i].cnt, 1'b1));
      end
      send(DirTbl[i].lo, DirTbl[i].up, !DirTbl[i].chk);
    end

    for (ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 69 : 0;
      rx_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 19 : 0;
      if (ph == 0) begin
        // tallest frame, height saturated from above the range
        set_geometry(9'd2, 9'd300, 9'd0, rand_coord(2), rand_coord(256),
                     rand_coord(2), rand_coord(256));
        run_frame(1'b0);
      end
      if (ph == 2) begin
        // widest frame, width saturated, full window; alternating columns
        // make every cell a point, so the held-off output stalls the input
        set_geometry(9'd511, 9'd2, 9'($urandom_range(511, 0)), 9'd0, 9'd0,
                     9'd256, 9'd256);
        hold_arm = ~hold_arm;
        for (int k = 0; k < 2 * int'(MaxWidth); k++) begin
          send(8'(k & 1), 8'((k >> 1) & 1), 1'b1);
        end
      end
      while (pairs_sent < DirRows + (ph + 1) * RandItems / 3) begin
        w_raw = $urandom_range(12, 0);
        h_raw = $urandom_range(8, 0);
        set_geometry(9'(w_raw), 9'(h_raw), 9'($urandom_range(511, 0)),
                     rand_coord(w_raw), rand_coord(h_raw),
                     rand_coord(w_raw), rand_coord(h_raw));
        run_frame($urandom_range(99, 0) < 20);
      end
    end

    settle();
    $display("Run covered %0d voxel pairs over %0d register settings,", pairs_sent,
             settings_cnt);
    $display("checking %0d surface points and %0d frame summaries.", points_seen,
             summaries_seen);
    if (fail_cnt == 0 && cells_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/isc_pkg.sv
sv/isc_front.sv
sv/isc_queue.sv
sv/isc_back.sv
sv/iso_surface_cell_classifier.sv
tb/tb_iso_surface_cell_classifier.sv
